FILE: hw/rtl/newton_interpolation_engine_core_defines.svh
// ----------------------------------------------------------------------------
// Newton interpolation engine assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef NEWTON_INTERPOLATION_ENGINE_CORE_DEFINES_SVH
`define NEWTON_INTERPOLATION_ENGINE_CORE_DEFINES_SVH

// checked outside reset
`define NIE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked during reset too
`define NIE_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/nie_pkg.sv
// ----------------------------------------------------------------------------
// nie_pkg
// Types, codes and helpers of the Newton interpolation engine.
// ----------------------------------------------------------------------------
package nie_pkg;

   localparam int DATA_W = 32;
   localparam int DIFF_W = DATA_W + 1;
   localparam int MUL_W  = 2 * DIFF_W;
   localparam int OP_W   = 2;
   localparam int ST_W   = 3;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_EVAL   = 2'd2;

   localparam logic [ST_W-1:0] ST_OK     = 3'd0;
   localparam logic [ST_W-1:0] ST_FULL   = 3'd1;
   localparam logic [ST_W-1:0] ST_EMPTY  = 3'd2;
   localparam logic [ST_W-1:0] ST_REPEAT = 3'd3;
   localparam logic [ST_W-1:0] ST_SAT    = 3'd4;

   localparam logic signed [MUL_W-1:0] SAT_MAX = 66'sh7FFFFFFF;
   localparam logic signed [MUL_W-1:0] SAT_MIN = -66'sh80000000;

   typedef struct packed {
      logic                     start;
      logic signed [DIFF_W-1:0] num;
      logic signed [DIFF_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic                     sat;
      logic signed [DATA_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic                     sat;
      logic signed [DATA_W-1:0] val;
   } sat_type;

   function automatic sat_type sat32(input logic signed [MUL_W-1:0] v);
      sat_type r;
      r.sat = 1'b0;
      r.val = v[DATA_W-1:0];
      if (v > SAT_MAX) begin
         r.sat = 1'b1;
         r.val = SAT_MAX[DATA_W-1:0];
      end else if (v < SAT_MIN) begin
         r.sat = 1'b1;
         r.val = SAT_MIN[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/nie_ram.sv
// ----------------------------------------------------------------------------
// nie_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module nie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/nie_div.sv
// ----------------------------------------------------------------------------
// nie_div
// Serial signed divider, one quotient bit per cycle, truncating, saturating.
// ----------------------------------------------------------------------------
module nie_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  nie_pkg::div_req_type div_req,
   output nie_pkg::div_rsp_type div_rsp
);
   import nie_pkg::*;

   localparam int DW     = DIFF_W + FRAC_BITS;
   localparam int STEP_W = $clog2(DW);

   logic              busy_ff, done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DW-1:0]     dvd_ff, quo_ff;
   logic [DIFF_W:0]   rem_ff;
   logic [DIFF_W-1:0] dsr_ff;
   logic              neg_ff;

   logic [DIFF_W-1:0] num_mag, den_mag;
   logic [DIFF_W:0]   trial, diff;
   logic              fits, last;

   assign num_mag = div_req.num[DIFF_W-1] ? DIFF_W'(-div_req.num) : DIFF_W'(div_req.num);
   assign den_mag = div_req.den[DIFF_W-1] ? DIFF_W'(-div_req.den) : DIFF_W'(div_req.den);
   assign trial   = {rem_ff[DIFF_W-1:0], dvd_ff[DW-1]};
   assign fits    = trial >= {1'b0, dsr_ff};
   assign diff    = trial - {1'b0, dsr_ff};
   assign last    = step_ff == STEP_W'(DW - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff & last;
         if (div_req.start) begin
            busy_ff <= 1'b1;
         end else if (last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         dvd_ff  <= {num_mag, FRAC_BITS'(0)};
         rem_ff  <= '0;
         quo_ff  <= '0;
         dsr_ff  <= den_mag;
         step_ff <= '0;
         neg_ff  <= div_req.num[DIFF_W-1] ^ div_req.den[DIFF_W-1];
      end else if (busy_ff) begin
         rem_ff  <= fits ? diff : trial;
         quo_ff  <= {quo_ff[DW-2:0], fits};
         dvd_ff  <= dvd_ff << 1;
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   always_comb begin
      div_rsp.done = done_ff;
      div_rsp.sat  = 1'b0;
      div_rsp.quot = DATA_W'(quo_ff[DATA_W-1:0]);
      if (neg_ff) begin
         if (quo_ff > DW'(32'h8000_0000)) begin
            div_rsp.sat  = 1'b1;
            div_rsp.quot = SAT_MIN[DATA_W-1:0];
         end else begin
            div_rsp.quot = ~quo_ff[DATA_W-1:0] + DATA_W'(1);
         end
      end else if (quo_ff > DW'(32'h7FFF_FFFF)) begin
         div_rsp.sat  = 1'b1;
         div_rsp.quot = SAT_MAX[DATA_W-1:0];
      end
   end

endmodule

FILE: hw/rtl/newton_interpolation_engine_core.sv
// ----------------------------------------------------------------------------
// newton_interpolation_engine_core
// Newton divided-difference interpolation over stored points, signed fixed point.
// ----------------------------------------------------------------------------
// Requests on req_* carry op in tuser (clear, append, evaluate) and x, y in
// tdata; every request yields one response on rsp_* with value and status.
// Points, ordinates and coefficients sit in three RAMs with registered reads;
// a sequencer walks them one entry at a time.
// Clear and append only update the table. Evaluate with current coefficients
// walks the n points in turn. After an append, evaluate first rebuilds: it
// compares all abscissa pairs for repeats, copies the ordinates as starting
// coefficients, then forms n(n-1)/2 divided differences on the serial divider.
// One request is worked on at a time; req_tready is high only when idle.
// The response register frees the sequencer; if rsp_tready is low and a
// response already waits, the next result holds until it drains.
// Reset empties the table and clears the response; no RAM clearing pass is
// needed as only written entries are ever read.
// ----------------------------------------------------------------------------
module newton_interpolation_engine_core #(
   parameter int MAX_POINTS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [63:0]               req_tdata,   // abscissa, ordinate
   input  logic [nie_pkg::OP_W-1:0]  req_tuser,   // op
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata,   // value
   output logic [nie_pkg::ST_W-1:0]  rsp_tuser    // status
);
   import nie_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int ACC_W = 2 * DATA_W - FRAC_BITS + IDX_W + 1;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_RESP  = 5'd1;
   localparam logic [4:0] S_DUP_I = 5'd2;
   localparam logic [4:0] S_DUP_X = 5'd3;
   localparam logic [4:0] S_DUP_J = 5'd4;
   localparam logic [4:0] S_DUP_C = 5'd5;
   localparam logic [4:0] S_CP_R  = 5'd6;
   localparam logic [4:0] S_CP_W  = 5'd7;
   localparam logic [4:0] S_DD_A  = 5'd8;
   localparam logic [4:0] S_DD_B  = 5'd9;
   localparam logic [4:0] S_DD_C  = 5'd10;
   localparam logic [4:0] S_DD_W  = 5'd11;
   localparam logic [4:0] S_EV_R  = 5'd12;
   localparam logic [4:0] S_EV_M  = 5'd13;
   localparam logic [4:0] S_EV_A  = 5'd14;
   localparam logic [4:0] S_EV_P  = 5'd15;
   localparam logic [4:0] S_EV_F  = 5'd16;

   logic [4:0]               state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     stale_ff, stale_in;
   logic                     csat_ff, csat_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsat_ff, rsat_in;
   logic                     esat_ff, esat_in;
   logic [CNT_W-1:0]         i_ff, i_in, j_ff, j_in, k_ff, k_in, idx_ff, idx_in;
   logic signed [DATA_W-1:0] x_ff, x_in, xi_ff, xi_in, ck_ff, ck_in, xk_ff, xk_in;
   logic signed [DATA_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [MUL_W-1:0]  mul_ff;
   logic signed [DATA_W-1:0] res_value_ff, res_value_in, rsp_value_ff;
   logic [ST_W-1:0]          res_status_ff, res_status_in, rsp_status_ff;

   logic signed [DIFF_W-1:0] mul_a, mul_b;
   logic signed [MUL_W-1:0]  mul_sh;
   sat_type                  sat_r;

   logic             xy_we, c_we;
   logic [IDX_W-1:0] xy_waddr, c_waddr, x_raddr, y_raddr, c_raddr;
   logic [DATA_W-1:0] c_wdata, x_rd, y_rd, c_rd;
   logic signed [DATA_W-1:0] xs_rd, cs_rd;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic req_fire, rsp_free, rsat_now;

   assign xs_rd = $signed(x_rd);
   assign cs_rd = $signed(c_rd);

   nie_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_xram (
      .clock(clock), .wr_en(xy_we), .wr_addr(xy_waddr), .wr_data(req_tdata[31:0]),
      .rd_addr(x_raddr), .rd_data(x_rd));

   nie_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_yram (
      .clock(clock), .wr_en(xy_we), .wr_addr(xy_waddr), .wr_data(req_tdata[63:32]),
      .rd_addr(y_raddr), .rd_data(y_rd));

   nie_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_cram (
      .clock(clock), .wr_en(c_we), .wr_addr(c_waddr), .wr_data(c_wdata),
      .rd_addr(c_raddr), .rd_data(c_rd));

   nie_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   assign req_tready = state_ff == S_IDLE;
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign mul_sh     = mul_ff >>> FRAC_BITS;
   assign rsat_now   = rsat_ff | div_rsp.sat;

   // Accesses to one entry never overlap: each read of an entry is issued only
   // after the last write to it by the sequence itself.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      stale_in      = stale_ff;
      csat_in       = csat_ff;
      rsat_in       = rsat_ff;
      esat_in       = esat_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      idx_in        = idx_ff;
      x_in          = x_ff;
      xi_in         = xi_ff;
      ck_in         = ck_ff;
      xk_in         = xk_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      xy_we         = 1'b0;
      xy_waddr      = cnt_ff[IDX_W-1:0];
      c_we          = 1'b0;
      c_waddr       = i_ff[IDX_W-1:0];
      c_wdata       = y_rd;
      x_raddr       = i_ff[IDX_W-1:0];
      y_raddr       = i_ff[IDX_W-1:0];
      c_raddr       = i_ff[IDX_W-1:0];
      mul_a         = DIFF_W'(cs_rd);
      mul_b         = DIFF_W'(prod_ff);
      sat_r         = sat32(MUL_W'(acc_ff));
      div_req.start = 1'b0;
      div_req.num   = DIFF_W'(ck_ff) - DIFF_W'(cs_rd);
      div_req.den   = DIFF_W'(xk_ff) - DIFF_W'(xs_rd);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               x_in          = $signed(req_tdata[31:0]);
               res_value_in  = '0;
               res_status_in = ST_OK;
               state_in      = S_RESP;
               i_in          = '0;
               rsat_in       = 1'b0;
               case (req_tuser)
                  OP_CLEAR: begin
                     cnt_in   = '0;
                     stale_in = 1'b0;
                  end
                  OP_APPEND: begin
                     if (cnt_ff == CNT_W'(MAX_POINTS)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        xy_we    = 1'b1;
                        cnt_in   = cnt_ff + CNT_W'(1);
                        stale_in = 1'b1;
                     end
                  end
                  OP_EVAL: begin
                     if (cnt_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else if (stale_ff) begin
                        state_in = (cnt_ff == CNT_W'(1)) ? S_CP_R : S_DUP_I;
                     end else begin
                        esat_in  = csat_ff;
                        prod_in  = 32'sd1 <<< FRAC_BITS;
                        acc_in   = '0;
                        state_in = S_EV_R;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_DUP_I: begin
            j_in     = i_ff + CNT_W'(1);
            state_in = S_DUP_X;
         end
         S_DUP_X: begin
            xi_in    = xs_rd;
            state_in = S_DUP_J;
         end
         S_DUP_J: begin
            x_raddr  = j_ff[IDX_W-1:0];
            state_in = S_DUP_C;
         end
         S_DUP_C: begin
            if (xs_rd == xi_ff) begin
               res_status_in = ST_REPEAT;
               state_in      = S_RESP;
            end else if (j_ff + CNT_W'(1) < cnt_ff) begin
               j_in     = j_ff + CNT_W'(1);
               state_in = S_DUP_J;
            end else if (i_ff + CNT_W'(2) < cnt_ff) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = S_DUP_I;
            end else begin
               i_in     = '0;
               state_in = S_CP_R;
            end
         end
         S_CP_R: begin
            state_in = S_CP_W;
         end
         S_CP_W: begin
            c_we = 1'b1;
            if (i_ff + CNT_W'(1) < cnt_ff) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = S_CP_R;
            end else if (cnt_ff == CNT_W'(1)) begin
               csat_in  = 1'b0;
               esat_in  = 1'b0;
               stale_in = 1'b0;
               i_in     = '0;
               prod_in  = 32'sd1 <<< FRAC_BITS;
               acc_in   = '0;
               state_in = S_EV_R;
            end else begin
               idx_in   = '0;
               k_in     = cnt_ff - CNT_W'(1);
               state_in = S_DD_A;
            end
         end
         S_DD_A: begin
            x_raddr  = k_ff[IDX_W-1:0];
            c_raddr  = k_ff[IDX_W-1:0];
            state_in = S_DD_B;
         end
         S_DD_B: begin
            ck_in    = cs_rd;
            xk_in    = xs_rd;
            c_raddr  = k_ff[IDX_W-1:0] - IDX_W'(1);
            x_raddr  = IDX_W'(k_ff - idx_ff - CNT_W'(1));
            state_in = S_DD_C;
         end
         S_DD_C: begin
            div_req.start = 1'b1;
            state_in      = S_DD_W;
         end
         S_DD_W: begin
            c_waddr = k_ff[IDX_W-1:0];
            c_wdata = div_rsp.quot;
            if (div_rsp.done) begin
               c_we    = 1'b1;
               rsat_in = rsat_now;
               if (k_ff - CNT_W'(1) > idx_ff) begin
                  k_in     = k_ff - CNT_W'(1);
                  state_in = S_DD_A;
               end else if (idx_ff + CNT_W'(2) < cnt_ff) begin
                  idx_in   = idx_ff + CNT_W'(1);
                  k_in     = cnt_ff - CNT_W'(1);
                  state_in = S_DD_A;
               end else begin
                  csat_in  = rsat_now;
                  esat_in  = rsat_now;
                  stale_in = 1'b0;
                  i_in     = '0;
                  prod_in  = 32'sd1 <<< FRAC_BITS;
                  acc_in   = '0;
                  state_in = S_EV_R;
               end
            end
         end
         S_EV_R: begin
            state_in = S_EV_M;
         end
         S_EV_M: begin
            xi_in    = xs_rd;
            state_in = S_EV_A;
         end
         S_EV_A: begin
            acc_in = acc_ff + ACC_W'(mul_sh);
            mul_a  = DIFF_W'(prod_ff);
            mul_b  = DIFF_W'(x_ff) - DIFF_W'(xi_ff);
            if (i_ff + CNT_W'(1) < cnt_ff) begin
               state_in = S_EV_P;
            end else begin
               state_in = S_EV_F;
            end
         end
         S_EV_P: begin
            sat_r    = sat32(mul_sh);
            prod_in  = sat_r.val;
            esat_in  = esat_ff | sat_r.sat;
            i_in     = i_ff + CNT_W'(1);
            state_in = S_EV_R;
         end
         S_EV_F: begin
            res_value_in  = sat_r.val;
            res_status_in = (esat_ff | sat_r.sat) ? ST_SAT : ST_OK;
            state_in      = S_RESP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         stale_ff     <= 1'b0;
         csat_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         stale_ff     <= stale_in;
         csat_ff      <= csat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsat_ff       <= rsat_in;
      esat_ff       <= esat_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      idx_ff        <= idx_in;
      x_ff          <= x_in;
      xi_ff         <= xi_in;
      ck_ff         <= ck_in;
      xk_ff         <= xk_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      mul_ff        <= mul_a * mul_b;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      if (state_ff == S_RESP && rsp_free) begin
         rsp_value_ff  <= res_value_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

FILE: hw/rtl/nie_checker.sv
// ----------------------------------------------------------------------------
// nie_checker
// Port-level checks of the Newton interpolation engine, bound to the core.
// ----------------------------------------------------------------------------
`include "newton_interpolation_engine_core_defines.svh"

module nie_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [63:0]              req_tdata,
   input logic [nie_pkg::OP_W-1:0] req_tuser,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [31:0]              rsp_tdata,
   input logic [nie_pkg::ST_W-1:0] rsp_tuser
);
   import nie_pkg::*;

   logic              err_status;
   logic              rsp_stall;
   logic [ST_W+31:0]  rsp_word;

   assign err_status = rsp_tuser == ST_FULL || rsp_tuser == ST_EMPTY || rsp_tuser == ST_REPEAT;
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_word   = {rsp_tuser, rsp_tdata};

   `NIE_ASSERT_RST(a_reset_clears_rsp, reset |=> !rsp_tvalid, "response valid after reset")

   `NIE_ASSERT(a_status_legal, rsp_tvalid |-> rsp_tuser <= ST_SAT, "illegal status code")

   `NIE_ASSERT(a_error_value_zero, rsp_tvalid && err_status |-> rsp_tdata == '0, "error value")

   `NIE_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_word), "stalled response")

endmodule

bind newton_interpolation_engine_core nie_checker u_nie_checker (.*);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Newton interpolation engine testbench
// Drives clear, append, evaluate and unused-op requests with random idling on
// both sides. An in-bench fixed-point interpolator predicts every response, and
// each response is checked field by field against it.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import nie_pkg::*;

   localparam int NPTS = 16;
   localparam int FRAC = 16;
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam longint CYCLE_LIMIT = 4000000;
   localparam int N_ITEMS = 1200;

   typedef struct {
      logic signed [31:0] value;
      logic [ST_W-1:0]    status;
   } interp_result_type;

   class interp_scoreboard_type;
      logic signed [31:0] xs[NPTS];
      logic signed [31:0] ys[NPTS];
      logic signed [31:0] cf[NPTS];
      int    cnt;
      bit    stale, coef_sat;
      interp_result_type awaited[$];
      int    errors;
      int    seen[8];

      function logic signed [31:0] clip(input logic signed [95:0] v, inout bit f);
         if (v > 96'sh7FFFFFFF) begin
            f = 1;
            return 32'sh7FFFFFFF;
         end
         if (v < -96'sh80000000) begin
            f = 1;
            return 32'sh80000000;
         end
         return v[31:0];
      endfunction

      function bit divided_differences();
         logic signed [31:0] c[NPTS];
         logic signed [95:0] num, den, q;
         bit f;
         f = 0;
         for (int i = 0; i < cnt; i++)
            for (int j = i + 1; j < cnt; j++)
               if (xs[i] == xs[j]) return 0;
         for (int i = 0; i < cnt; i++) c[i] = ys[i];
         for (int d = 0; d < cnt; d++)
            for (int k = cnt - 1; k > d; k--) begin
               num = c[k] - c[k-1];
               den = xs[k] - xs[k-d-1];
               q = (num * 96'sd65536) / den;
               c[k] = clip(q, f);
            end
         for (int i = 0; i < cnt; i++) cf[i] = c[i];
         coef_sat = f;
         stale = 0;
         return 1;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic signed [31:0] x,
                                 logic signed [31:0] y);
         interp_result_type r;
         logic signed [95:0] acc, t, dx;
         logic signed [31:0] prod;
         bit f;
         r.value = 0;
         r.status = ST_OK;
         case (op)
            OP_CLEAR: begin
               cnt = 0;
               stale = 0;
            end
            OP_APPEND: begin
               if (cnt >= NPTS) r.status = ST_FULL;
               else begin
                  xs[cnt] = x;
                  ys[cnt] = y;
                  cnt++;
                  stale = 1;
               end
            end
            OP_EVAL: begin
               if (cnt == 0) r.status = ST_EMPTY;
               else if (stale && !divided_differences()) r.status = ST_REPEAT;
               else begin
                  f = coef_sat;
                  acc = 0;
                  prod = 32'sd65536;
                  for (int i = 0; i < cnt; i++) begin
                     t = cf[i] * prod;
                     acc = acc + (t >>> FRAC);
                     if (i + 1 < cnt) begin
                        dx = x - xs[i];
                        t = prod * dx;
                        prod = clip(t >>> FRAC, f);
                     end
                  end
                  r.value = clip(acc, f);
                  if (f) r.status = ST_SAT;
               end
            end
            default: ;
         endcase
         awaited.insert(awaited.size(), r);
      endfunction

      function void check_response(logic [31:0] data, logic [ST_W-1:0] st);
         interp_result_type e;
         if (awaited.size() == 0) begin
            $error("response with none expected: value %h status %0d", data, st);
            errors++;
            return;
         end
         e = awaited.pop_front();
         seen[e.status]++;
         if (data !== e.value) begin
            $error("value: expected %h, actual %h", e.value, data);
            errors++;
         end
         if (st !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, st);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] req_tdata;
   logic [OP_W-1:0] req_tuser;
   logic [31:0] rsp_tdata;
   logic [ST_W-1:0] rsp_tuser;

   interp_scoreboard_type sb;
   longint cycles = 0;
   int sent;
   logic signed [31:0] used_x[$];

   newton_interpolation_engine_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // no idling in this window
   function bit quiet();
      return cycles > 20000 && cycles < 60000;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
         rsp_tready <= quiet() || $urandom_range(99) >= 16;
      end
   end

   task automatic send(logic [OP_W-1:0] op, logic signed [31:0] x, logic signed [31:0] y);
      while (!quiet() && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {y, x};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      sb.note_request(op, x, y);
      sent++;
   endtask

   function logic signed [31:0] rand_word();
      return $urandom;
   endfunction

   // x in +-8.0 mostly, occasionally full range
   function logic signed [31:0] rand_x();
      if ($urandom_range(9) == 0) return rand_word();
      return $signed($urandom_range(1048576)) - 32'sd524288;
   endfunction

   function logic signed [31:0] rand_y();
      if ($urandom_range(9) == 0) return rand_word();
      return $signed($urandom_range(13107200)) - 32'sd6553600;
   endfunction

   task automatic point_set(int n);
      logic signed [31:0] x;
      send(OP_CLEAR, rand_word(), rand_word());
      used_x.delete();
      for (int i = 0; i < n; i++) begin
         if (used_x.size() > 0 && $urandom_range(19) == 0)
            x = used_x[$urandom_range(used_x.size() - 1)];
         else
            x = rand_x();
         used_x.insert(used_x.size(), x);
         send(OP_APPEND, x, rand_y());
      end
   endtask

   initial begin
      int n;
      sb = new();
      sent = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_CLEAR;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed
      send(OP_EVAL, 32'sh7FFFFFFF, 0);
      send(OP_SPARE, 32'shFFFFFFFF, 32'shFFFFFFFF);
      send(OP_APPEND, 32'sh00010000, 32'sh00020000);
      send(OP_EVAL, 32'sh80000000, 0);
      send(OP_APPEND, 32'sh00020000, 32'shFFFF0000);
      send(OP_APPEND, 32'sh00010000, 32'sh00050000);
      send(OP_EVAL, 32'sh00018000, 0);
      send(OP_CLEAR, 0, 0);
      send(OP_APPEND, 32'sh00000000, 32'sh00000000);
      send(OP_APPEND, 32'sh00000001, 32'sh7FFFFFFF);
      send(OP_EVAL, 32'sh00000000, 0);
      send(OP_CLEAR, 0, 0);
      send(OP_APPEND, 32'sh80000000, 32'sh80000000);
      send(OP_APPEND, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send(OP_EVAL, 32'sh7FFFFFFF, 0);
      send(OP_EVAL, 32'sh00000000, 0);
      send(OP_CLEAR, 0, 0);
      for (int i = 0; i < NPTS; i++)
         send(OP_APPEND, (i - 8) * 32'sh00008000, (i * i) * 32'sh00001000);
      send(OP_APPEND, 32'sh00100000, 32'sh00100000);
      send(OP_EVAL, 32'sh00004000, 0);
      send(OP_EVAL, 32'shFFFC0000, 0);

      // random: mostly well-formed point sets followed by queries
      while (sent < N_ITEMS) begin
         if ($urandom_range(9) == 0) begin
            send(OP_W'($urandom_range(3)), rand_word(), rand_word());
         end else begin
            n = ($urandom_range(24) == 0) ? $urandom_range(12, NPTS + 2)
                                          : $urandom_range(0, 5);
            point_set(n);
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(7) == 0) send(OP_APPEND, rand_x(), rand_y());
               send(OP_EVAL, rand_x(), rand_word());
            end
         end
      end
      @(posedge clock);
      req_tvalid <= 1'b0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("requests %0d: ok %0d, full %0d, empty %0d, repeat %0d, saturated %0d",
               sent, sb.seen[ST_OK], sb.seen[ST_FULL], sb.seen[ST_EMPTY],
               sb.seen[ST_REPEAT], sb.seen[ST_SAT]);
      if (sb.errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
